FILE: src/lacb_pkg.sv
// Shared constants for the look-at camera basis pipeline.
// No dependencies; used by lacb_normalize and look_at_camera_basis_top.
package lacb_pkg;

  localparam int NORM_MAG_BITS = 30;
  localparam int SQRT_STEPS    = 2;
  localparam int DIV_STEPS     = 2;

  localparam int CASE_W = 2;
  localparam logic [CASE_W-1:0] CASE_GENERAL = 2'd0;
  localparam logic [CASE_W-1:0] CASE_DOWN    = 2'd1;
  localparam logic [CASE_W-1:0] CASE_UP      = 2'd2;
  localparam logic [CASE_W-1:0] CASE_DEGEN   = 2'd3;

endpackage

FILE: src/look_at_camera_basis_top.sv
// Pipeline at default widths: three normalizers of 29, 32 and 32 stages,
// two 2-stage cross products, input and output registers. Throughput: one
// transfer per cycle; the whole pipeline holds while a result waits.
// rst_n (synchronous, active low) clears every valid bit; payload registers
// are not reset.
// Top level of the look-at camera basis; uses lacb_pkg and lacb_normalize.
module look_at_camera_basis_top #(
  parameter int COORD_BITS     = 24,
  parameter int UNIT_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COORD_BITS-1:0] in_eye_x,
  input  logic signed [COORD_BITS-1:0] in_eye_y,
  input  logic signed [COORD_BITS-1:0] in_eye_z,
  input  logic signed [COORD_BITS-1:0] in_target_x,
  input  logic signed [COORD_BITS-1:0] in_target_y,
  input  logic signed [COORD_BITS-1:0] in_target_z,
  input  logic signed [COORD_BITS-1:0] in_up_x,
  input  logic signed [COORD_BITS-1:0] in_up_y,
  input  logic signed [COORD_BITS-1:0] in_up_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [UNIT_FRAC_BITS+1:0] out_u_x,
  output logic signed [UNIT_FRAC_BITS+1:0] out_u_y,
  output logic signed [UNIT_FRAC_BITS+1:0] out_u_z,
  output logic signed [UNIT_FRAC_BITS+1:0] out_v_x,
  output logic signed [UNIT_FRAC_BITS+1:0] out_v_y,
  output logic signed [UNIT_FRAC_BITS+1:0] out_v_z,
  output logic signed [UNIT_FRAC_BITS+1:0] out_w_x,
  output logic signed [UNIT_FRAC_BITS+1:0] out_w_y,
  output logic signed [UNIT_FRAC_BITS+1:0] out_w_z,
  output logic [lacb_pkg::CASE_W-1:0]  out_basis_case
);

  localparam int CB  = COORD_BITS;
  localparam int F   = UNIT_FRAC_BITS;
  localparam int UW  = F + 2;
  localparam int DW  = CB + 1;
  localparam int P1W = CB + UW;
  localparam int T1W = P1W + 1;
  localparam int P2W = 2 * UW;
  localparam int T2W = P2W + 1;
  localparam int CW  = lacb_pkg::CASE_W;
  localparam int SB1 = 3 * CB + CW;
  localparam int SB2 = 3 * UW + 1 + CW;
  localparam int SB3 = 6 * UW + 1 + CW;
  localparam logic signed [UW-1:0] ONE = UW'(1) << F;

  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // input stage: difference and special-case detection
  logic signed [DW-1:0] dx, dy, dz;
  logic [CW-1:0]        case_nxt;
  logic                 v0_r;
  logic signed [DW-1:0] d_r [3];
  logic signed [CB-1:0] up_r [3];
  logic [CW-1:0]        case_r;

  always_comb begin
    dx = DW'(in_eye_x) - DW'(in_target_x);
    dy = DW'(in_eye_y) - DW'(in_target_y);
    dz = DW'(in_eye_z) - DW'(in_target_z);
    case_nxt = lacb_pkg::CASE_GENERAL;
    if (dx == '0 && dz == '0) begin
      if (dy > 0) case_nxt = lacb_pkg::CASE_DOWN;
      else if (dy < 0) case_nxt = lacb_pkg::CASE_UP;
      else case_nxt = lacb_pkg::CASE_DEGEN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r[0]  <= dx;
      d_r[1]  <= dy;
      d_r[2]  <= dz;
      up_r[0] <= in_up_x;
      up_r[1] <= in_up_y;
      up_r[2] <= in_up_z;
      case_r  <= case_nxt;
    end
  end

  // normalize w
  logic                 wn_v, wn_ok;
  logic signed [UW-1:0] wn [3];
  logic [SB1-1:0]       wn_sb;

  lacb_normalize #(.IW(DW), .F(F), .SBW(SB1)) u_norm_w (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v0_r),
    .in_a(d_r[0]), .in_b(d_r[1]), .in_c(d_r[2]),
    .in_sb({up_r[0], up_r[1], up_r[2], case_r}),
    .out_valid(wn_v), .out_x(wn[0]), .out_y(wn[1]), .out_z(wn[2]),
    .out_ok(wn_ok), .out_sb(wn_sb)
  );

  logic signed [CB-1:0] upw [3];
  assign upw[0] = wn_sb[CW+3*CB-1 -: CB];
  assign upw[1] = wn_sb[CW+2*CB-1 -: CB];
  assign upw[2] = wn_sb[CW+CB-1 -: CB];

  // cross(up, w): products then differences
  logic                  c1a_v_r, c1a_ok_r;
  logic signed [P1W-1:0] c1a_p_r [6];
  logic signed [UW-1:0]  c1a_w_r [3];
  logic [CW-1:0]         c1a_case_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1a_v_r <= 1'b0;
    end else if (adv) begin
      c1a_v_r <= wn_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1a_p_r[0] <= P1W'(upw[1]) * P1W'(wn[2]);
      c1a_p_r[1] <= P1W'(upw[2]) * P1W'(wn[1]);
      c1a_p_r[2] <= P1W'(upw[2]) * P1W'(wn[0]);
      c1a_p_r[3] <= P1W'(upw[0]) * P1W'(wn[2]);
      c1a_p_r[4] <= P1W'(upw[0]) * P1W'(wn[1]);
      c1a_p_r[5] <= P1W'(upw[1]) * P1W'(wn[0]);
      c1a_w_r    <= wn;
      c1a_ok_r   <= wn_ok;
      c1a_case_r <= wn_sb[CW-1:0];
    end
  end

  logic                  c1b_v_r, c1b_ok_r;
  logic signed [T1W-1:0] c1b_t_r [3];
  logic signed [UW-1:0]  c1b_w_r [3];
  logic [CW-1:0]         c1b_case_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1b_v_r <= 1'b0;
    end else if (adv) begin
      c1b_v_r <= c1a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c1b_t_r[i] <= T1W'(c1a_p_r[2*i]) - T1W'(c1a_p_r[2*i+1]);
      end
      c1b_w_r    <= c1a_w_r;
      c1b_ok_r   <= c1a_ok_r;
      c1b_case_r <= c1a_case_r;
    end
  end

  // normalize u
  logic                 un_v, un_ok;
  logic signed [UW-1:0] un [3];
  logic [SB2-1:0]       un_sb;

  lacb_normalize #(.IW(T1W), .F(F), .SBW(SB2)) u_norm_u (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(c1b_v_r),
    .in_a(c1b_t_r[0]), .in_b(c1b_t_r[1]), .in_c(c1b_t_r[2]),
    .in_sb({c1b_w_r[0], c1b_w_r[1], c1b_w_r[2], c1b_ok_r, c1b_case_r}),
    .out_valid(un_v), .out_x(un[0]), .out_y(un[1]), .out_z(un[2]),
    .out_ok(un_ok), .out_sb(un_sb)
  );

  logic signed [UW-1:0] uw [3];
  assign uw[0] = un_sb[CW+1+3*UW-1 -: UW];
  assign uw[1] = un_sb[CW+1+2*UW-1 -: UW];
  assign uw[2] = un_sb[CW+1+UW-1 -: UW];

  // cross(w, u)
  logic                  c2a_v_r, c2a_ok_r;
  logic signed [P2W-1:0] c2a_p_r [6];
  logic signed [UW-1:0]  c2a_w_r [3];
  logic signed [UW-1:0]  c2a_u_r [3];
  logic [CW-1:0]         c2a_case_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2a_v_r <= 1'b0;
    end else if (adv) begin
      c2a_v_r <= un_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2a_p_r[0] <= P2W'(uw[1]) * P2W'(un[2]);
      c2a_p_r[1] <= P2W'(uw[2]) * P2W'(un[1]);
      c2a_p_r[2] <= P2W'(uw[2]) * P2W'(un[0]);
      c2a_p_r[3] <= P2W'(uw[0]) * P2W'(un[2]);
      c2a_p_r[4] <= P2W'(uw[0]) * P2W'(un[1]);
      c2a_p_r[5] <= P2W'(uw[1]) * P2W'(un[0]);
      c2a_w_r    <= uw;
      c2a_u_r    <= un;
      c2a_ok_r   <= un_sb[CW] && un_ok;
      c2a_case_r <= un_sb[CW-1:0];
    end
  end

  logic                  c2b_v_r, c2b_ok_r;
  logic signed [T2W-1:0] c2b_t_r [3];
  logic signed [UW-1:0]  c2b_w_r [3];
  logic signed [UW-1:0]  c2b_u_r [3];
  logic [CW-1:0]         c2b_case_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2b_v_r <= 1'b0;
    end else if (adv) begin
      c2b_v_r <= c2a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c2b_t_r[i] <= T2W'(c2a_p_r[2*i]) - T2W'(c2a_p_r[2*i+1]);
      end
      c2b_w_r    <= c2a_w_r;
      c2b_u_r    <= c2a_u_r;
      c2b_ok_r   <= c2a_ok_r;
      c2b_case_r <= c2a_case_r;
    end
  end

  // normalize v
  logic                 vn_v, vn_ok;
  logic signed [UW-1:0] vn [3];
  logic [SB3-1:0]       vn_sb;

  lacb_normalize #(.IW(T2W), .F(F), .SBW(SB3)) u_norm_v (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(c2b_v_r),
    .in_a(c2b_t_r[0]), .in_b(c2b_t_r[1]), .in_c(c2b_t_r[2]),
    .in_sb({c2b_w_r[0], c2b_w_r[1], c2b_w_r[2],
            c2b_u_r[0], c2b_u_r[1], c2b_u_r[2], c2b_ok_r, c2b_case_r}),
    .out_valid(vn_v), .out_x(vn[0]), .out_y(vn[1]), .out_z(vn[2]),
    .out_ok(vn_ok), .out_sb(vn_sb)
  );

  // result selection
  logic signed [UW-1:0] fw [3];
  logic signed [UW-1:0] fu [3];
  logic [CW-1:0]        fcase;
  logic signed [UW-1:0] res_nxt [9];
  logic [CW-1:0]        case_out_nxt;

  assign fw[0] = vn_sb[CW+1+6*UW-1 -: UW];
  assign fw[1] = vn_sb[CW+1+5*UW-1 -: UW];
  assign fw[2] = vn_sb[CW+1+4*UW-1 -: UW];
  assign fu[0] = vn_sb[CW+1+3*UW-1 -: UW];
  assign fu[1] = vn_sb[CW+1+2*UW-1 -: UW];
  assign fu[2] = vn_sb[CW+1+UW-1 -: UW];
  assign fcase = vn_sb[CW-1:0];

  always_comb begin
    for (int i = 0; i < 9; i++) res_nxt[i] = '0;
    case_out_nxt = fcase;
    case (fcase)
      lacb_pkg::CASE_DOWN: begin
        res_nxt[2] = ONE;
        res_nxt[3] = ONE;
        res_nxt[7] = ONE;
      end
      lacb_pkg::CASE_UP: begin
        res_nxt[0] = ONE;
        res_nxt[5] = ONE;
        res_nxt[7] = -ONE;
      end
      lacb_pkg::CASE_GENERAL: begin
        if (vn_sb[CW] && vn_ok) begin
          for (int i = 0; i < 3; i++) begin
            res_nxt[i]   = fu[i];
            res_nxt[3+i] = vn[i];
            res_nxt[6+i] = fw[i];
          end
        end else begin
          case_out_nxt = lacb_pkg::CASE_DEGEN;
        end
      end
      default: begin
        case_out_nxt = lacb_pkg::CASE_DEGEN;
      end
    endcase
  end

  logic signed [UW-1:0] res_r [9];
  logic [CW-1:0]        case_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vn_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r      <= res_nxt;
      case_out_r <= case_out_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_u_x        = res_r[0];
  assign out_u_y        = res_r[1];
  assign out_u_z        = res_r[2];
  assign out_v_x        = res_r[3];
  assign out_v_y        = res_r[4];
  assign out_v_z        = res_r[5];
  assign out_w_x        = res_r[6];
  assign out_w_y        = res_r[7];
  assign out_w_z        = res_r[8];
  assign out_basis_case = case_out_r;

`ifndef NO_ASSERTIONS
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && case_out_r == lacb_pkg::CASE_DEGEN |->
      res_r[0] == '0 && res_r[4] == '0 && res_r[8] == '0 && res_r[2] == '0)
    else $error("degenerate result carries a non-zero axis");

  a_general_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && case_out_r == lacb_pkg::CASE_GENERAL |->
      res_r[6] != '0 || res_r[7] != '0 || res_r[8] != '0)
    else $error("general result with zero view axis");

  a_down_basis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && case_out_r == lacb_pkg::CASE_DOWN |->
      res_r[2] == ONE && res_r[3] == ONE && res_r[7] == ONE)
    else $error("straight-down basis wrong");
`endif

endmodule

FILE: src/lacb_normalize.sv
// Pipelined 3-vector normalizer: range shift, sum of squares, digit-serial
// square root stages and restoring division stages. Uses lacb_pkg.
module lacb_normalize #(
  parameter int IW  = 25,
  parameter int F   = 16,
  parameter int SBW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [IW-1:0] in_a,
  input  logic signed [IW-1:0] in_b,
  input  logic signed [IW-1:0] in_c,
  input  logic [SBW-1:0]      in_sb,
  output logic                out_valid,
  output logic signed [F+1:0] out_x,
  output logic signed [F+1:0] out_y,
  output logic signed [F+1:0] out_z,
  output logic                out_ok,
  output logic [SBW-1:0]      out_sb
);

  localparam int NM     = lacb_pkg::NORM_MAG_BITS;
  localparam int MAGW   = IW;
  localparam int SMW    = (MAGW > NM) ? NM : MAGW;
  localparam int SW     = $clog2(MAGW + 1);
  localparam int RW     = SMW + 1;
  localparam int SQ_ST  = (RW + lacb_pkg::SQRT_STEPS - 1) / lacb_pkg::SQRT_STEPS;
  localparam int NSQ    = SQ_ST * lacb_pkg::SQRT_STEPS;
  localparam int QW     = F + 1;
  localparam int DV_ST  = (QW + lacb_pkg::DIV_STEPS - 1) / lacb_pkg::DIV_STEPS;
  localparam int NDV    = DV_ST * lacb_pkg::DIV_STEPS;
  localparam int NW     = SMW + F + 1;
  localparam logic [SW-1:0]  NM_S = SW'(NM);
  localparam logic [NDV-1:0] ONE_Q = NDV'(1) << F;

  // stage 1: sign and magnitude
  logic                 v1_r;
  logic [2:0]           neg1_r;
  logic [MAGW-1:0]      mag1_r [3];
  logic [SBW-1:0]       sb1_r;
  logic signed [IW-1:0] vin [3];

  assign vin[0] = in_a;
  assign vin[1] = in_b;
  assign vin[2] = in_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1_r[i] <= vin[i][IW-1];
        mag1_r[i] <= vin[i][IW-1] ? MAGW'(~vin[i] + 1'b1) : MAGW'(vin[i]);
      end
      sb1_r <= in_sb;
    end
  end

  // stage 2: range shift search
  logic            v2_r, zero2_r;
  logic [2:0]      neg2_r;
  logic [MAGW-1:0] mag2_r [3];
  logic [SW-1:0]   sh2_r;
  logic [SBW-1:0]  sb2_r;
  logic [MAGW-1:0] mx;
  logic [SW-1:0]   bl;
  logic [SW-1:0]   sh2_nxt;

  always_comb begin
    mx = mag1_r[0];
    if (mag1_r[1] > mx) mx = mag1_r[1];
    if (mag1_r[2] > mx) mx = mag1_r[2];
    bl = '0;
    for (int i = 0; i < MAGW; i++) begin
      if (mx[i]) bl = SW'(i + 1);
    end
    sh2_nxt = (bl > NM_S) ? bl - NM_S : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero2_r <= (mx == '0);
      neg2_r  <= neg1_r;
      mag2_r  <= mag1_r;
      sh2_r   <= sh2_nxt;
      sb2_r   <= sb1_r;
    end
  end

  // stage 3: shift
  logic           v3_r, zero3_r;
  logic [2:0]     neg3_r;
  logic [SMW-1:0] sm3_r [3];
  logic [SBW-1:0] sb3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sm3_r[i] <= SMW'(mag2_r[i] >> sh2_r);
      end
      zero3_r <= zero2_r;
      neg3_r  <= neg2_r;
      sb3_r   <= sb2_r;
    end
  end

  // stage 4: squares
  logic             v4_r, zero4_r;
  logic [2:0]       neg4_r;
  logic [SMW-1:0]   sm4_r [3];
  logic [2*SMW-1:0] sq4_r [3];
  logic [SBW-1:0]   sb4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= (2*SMW)'(sm3_r[i]) * (2*SMW)'(sm3_r[i]);
      end
      sm4_r   <= sm3_r;
      zero4_r <= zero3_r;
      neg4_r  <= neg3_r;
      sb4_r   <= sb3_r;
    end
  end

  // stage 5 and square root stages
  logic             sq_v_r    [SQ_ST+1];
  logic             sq_zero_r [SQ_ST+1];
  logic [2:0]       sq_neg_r  [SQ_ST+1];
  logic [SMW-1:0]   sq_mag_r  [SQ_ST+1][3];
  logic [SBW-1:0]   sq_sb_r   [SQ_ST+1];
  logic [2*NSQ-1:0] sq_rad_r  [SQ_ST+1];
  logic [NSQ-1:0]   sq_root_r [SQ_ST+1];
  logic [NSQ+1:0]   sq_rem_r  [SQ_ST+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rad_r[0]  <= (2*NSQ)'(sq4_r[0]) + (2*NSQ)'(sq4_r[1]) + (2*NSQ)'(sq4_r[2]);
      sq_root_r[0] <= '0;
      sq_rem_r[0]  <= '0;
      sq_zero_r[0] <= zero4_r;
      sq_neg_r[0]  <= neg4_r;
      sq_mag_r[0]  <= sm4_r;
      sq_sb_r[0]   <= sb4_r;
    end
  end

  for (genvar k = 0; k < SQ_ST; k++) begin : g_sqrt
    logic [2*NSQ-1:0] rad_nxt;
    logic [NSQ-1:0]   root_nxt;
    logic [NSQ+1:0]   rem_nxt;

    always_comb begin
      logic [NSQ+1:0] trial;
      rad_nxt  = sq_rad_r[k];
      root_nxt = sq_root_r[k];
      rem_nxt  = sq_rem_r[k];
      for (int j = 0; j < lacb_pkg::SQRT_STEPS; j++) begin
        rem_nxt = {rem_nxt[NSQ-1:0], rad_nxt[2*NSQ-1 -: 2]};
        trial   = {root_nxt, 2'b01};
        rad_nxt = rad_nxt << 2;
        if (rem_nxt >= trial) begin
          rem_nxt  = rem_nxt - trial;
          root_nxt = {root_nxt[NSQ-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[NSQ-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad_r[k+1]  <= rad_nxt;
        sq_root_r[k+1] <= root_nxt;
        sq_rem_r[k+1]  <= rem_nxt;
        sq_zero_r[k+1] <= sq_zero_r[k];
        sq_neg_r[k+1]  <= sq_neg_r[k];
        sq_mag_r[k+1]  <= sq_mag_r[k];
        sq_sb_r[k+1]   <= sq_sb_r[k];
      end
    end
  end

  // division set-up and restoring division stages
  logic           dv_v_r    [DV_ST+1];
  logic           dv_zero_r [DV_ST+1];
  logic [2:0]     dv_neg_r  [DV_ST+1];
  logic [SBW-1:0] dv_sb_r   [DV_ST+1];
  logic [RW-1:0]  dv_len_r  [DV_ST+1];
  logic [RW-1:0]  dv_rem_r  [DV_ST+1][3];
  logic [NDV-1:0] dv_low_r  [DV_ST+1][3];
  logic [NDV-1:0] dv_q_r    [DV_ST+1][3];
  logic [RW-1:0]  len0;
  logic [NW-1:0]  num0 [3];

  always_comb begin
    len0 = sq_root_r[SQ_ST][RW-1:0];
    if (sq_zero_r[SQ_ST]) len0 = RW'(1);
    for (int i = 0; i < 3; i++) begin
      num0[i] = (NW'(sq_mag_r[SQ_ST][i]) << F) + NW'(len0 >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[SQ_ST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= RW'(num0[i] >> NDV);
        dv_low_r[0][i] <= num0[i][NDV-1:0];
        dv_q_r[0][i]   <= '0;
      end
      dv_len_r[0]  <= len0;
      dv_zero_r[0] <= sq_zero_r[SQ_ST];
      dv_neg_r[0]  <= sq_neg_r[SQ_ST];
      dv_sb_r[0]   <= sq_sb_r[SQ_ST];
    end
  end

  for (genvar k = 0; k < DV_ST; k++) begin : g_div
    logic [RW-1:0]  rem_nxt [3];
    logic [NDV-1:0] low_nxt [3];
    logic [NDV-1:0] q_nxt   [3];

    always_comb begin
      logic [RW:0] t;
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i] = dv_rem_r[k][i];
        low_nxt[i] = dv_low_r[k][i];
        q_nxt[i]   = dv_q_r[k][i];
        for (int j = 0; j < lacb_pkg::DIV_STEPS; j++) begin
          t          = {rem_nxt[i], low_nxt[i][NDV-1]};
          low_nxt[i] = low_nxt[i] << 1;
          if (t >= {1'b0, dv_len_r[k]}) begin
            rem_nxt[i] = RW'(t - {1'b0, dv_len_r[k]});
            q_nxt[i]   = {q_nxt[i][NDV-2:0], 1'b1};
          end else begin
            rem_nxt[i] = t[RW-1:0];
            q_nxt[i]   = {q_nxt[i][NDV-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k+1]  <= rem_nxt;
        dv_low_r[k+1]  <= low_nxt;
        dv_q_r[k+1]    <= q_nxt;
        dv_len_r[k+1]  <= dv_len_r[k];
        dv_zero_r[k+1] <= dv_zero_r[k];
        dv_neg_r[k+1]  <= dv_neg_r[k];
        dv_sb_r[k+1]   <= dv_sb_r[k];
      end
    end
  end

  // output stage: clamp and sign
  logic                o_v_r, o_ok_r;
  logic signed [F+1:0] o_r [3];
  logic [SBW-1:0]      o_sb_r;
  logic [NDV-1:0]      qc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dv_q_r[DV_ST][i] > ONE_Q) ? ONE_Q : dv_q_r[DV_ST][i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= dv_v_r[DV_ST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        o_r[i] <= dv_neg_r[DV_ST][i] ? -$signed((F+2)'(qc[i])) : $signed((F+2)'(qc[i]));
      end
      o_ok_r <= !dv_zero_r[DV_ST];
      o_sb_r <= dv_sb_r[DV_ST];
    end
  end

  assign out_valid = o_v_r;
  assign out_x     = o_r[0];
  assign out_y     = o_r[1];
  assign out_z     = o_r[2];
  assign out_ok    = o_ok_r;
  assign out_sb    = o_sb_r;

endmodule
